>>> rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int GEN_W   = 32;
    localparam int DENSE_W = 16;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RESOLVE = 2'd1,
        KIND_UPDATE  = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_STALE = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // one slot entry: generation and dense index kept in the same word
    typedef struct packed {
        logic [GEN_W-1:0]   gen;
        logic [DENSE_W-1:0] dense;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic [DENSE_W-1:0] dense;
    } t_res;

endpackage

>>> rtl/ght_in_if.sv
`timescale 1ns / 1ps

interface ght_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  handle_slot;
    logic [31:0] handle_generation;
    logic [15:0] dense_value;

    modport source (output valid, kind, handle_slot, handle_generation, dense_value,
                    input ready);
    modport sink   (input valid, kind, handle_slot, handle_generation, dense_value,
                    output ready);
endinterface

>>> rtl/ght_out_if.sv
`timescale 1ns / 1ps

interface ght_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  out_slot;
    logic [31:0] out_generation;
    logic [15:0] out_dense;

    modport source (output valid, status, out_slot, out_generation, out_dense,
                    input ready);
    modport sink   (input valid, status, out_slot, out_generation, out_dense,
                    output ready);
endinterface

>>> rtl/ght_ram.sv
`timescale 1ns / 1ps

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ght_out_reg.sv
`timescale 1ns / 1ps

module ght_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ght_pkg::t_res     i_res,
    output logic              o_free,
    ght_out_if.source         o_out
);

    logic          r_valid;
    ght_pkg::t_res r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_res.status;
    assign o_out.out_slot       = r_res.slot;
    assign o_out.out_generation = r_res.gen;
    assign o_out.out_dense      = r_res.dense;

endmodule

>>> rtl/generational_handle_table_core.sv
`timescale 1ns / 1ps

// Generational handle table: alloc, resolve, update and release of slot handles
// over a fixed pool of ght_pkg::SLOTS slots. Slot entries (generation and dense
// index) live in one single-port-read RAM and the free slot stack in a second one,
// both with registered read data; one operation is worked at a time by a
// read-modify-write sequencer. Resolve, update and release read the slot entry
// and then check or write it back; an alloc that pops the free stack reads the
// stack, then the entry; a fresh alloc or an operation that is rejected goes
// straight to its result without a memory read. The result sits in an output register, so the
// next item is taken while an earlier result still waits for its sink. No memory
// clearing is needed after reset: only entries that were written are ever read.
module generational_handle_table_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ght_in_if.sink    i_in,
    ght_out_if.source o_out
);

    localparam int SLOT_W  = ght_pkg::SLOT_W;
    localparam int CNT_W   = ght_pkg::CNT_W;
    localparam int ENT_W   = $bits(ght_pkg::t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STK,
        S_ENT,
        S_RES
    } t_state;

    t_state                      r_state, n_state;
    ght_pkg::t_kind              r_kind, n_kind;
    logic [SLOT_W-1:0]           r_slot, n_slot;
    logic [ght_pkg::GEN_W-1:0]   r_gen, n_gen;
    logic [ght_pkg::DENSE_W-1:0] r_dense, n_dense;
    logic [CNT_W-1:0]            r_depth, n_depth;
    logic [CNT_W-1:0]            r_used, n_used;
    ght_pkg::t_res               r_res, n_res;

    logic              ent_we, ent_re;
    logic [SLOT_W-1:0] ent_waddr, ent_raddr;
    ght_pkg::t_entry   ent_wdata, ent_rdata;
    logic [ENT_W-1:0]  ent_rword;

    logic              stk_we, stk_re;
    logic [SLOT_W-1:0] stk_waddr, stk_raddr;
    logic [SLOT_W-1:0] stk_wdata, stk_rdata;

    logic              out_free, out_load;
    logic              accept;
    ght_pkg::t_kind    in_kind;
    logic              in_known;
    logic [CNT_W-1:0]  depth_dec;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign in_kind    = ght_pkg::t_kind'(i_in.kind);
    assign in_known   = {1'b0, i_in.handle_slot} < r_used;
    assign depth_dec  = r_depth - CNT_W'(1);
    assign ent_rdata  = ght_pkg::t_entry'(ent_rword);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_slot    = r_slot;
        n_gen     = r_gen;
        n_dense   = r_dense;
        n_depth   = r_depth;
        n_used    = r_used;
        n_res     = r_res;
        ent_we    = 1'b0;
        ent_waddr = r_slot;
        ent_wdata = '{gen: r_gen, dense: r_dense};
        ent_re    = 1'b0;
        ent_raddr = i_in.handle_slot;
        stk_we    = 1'b0;
        stk_waddr = r_depth[SLOT_W-1:0];
        stk_wdata = r_slot;
        stk_re    = 1'b0;
        stk_raddr = depth_dec[SLOT_W-1:0];
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind  = in_kind;
                    n_slot  = i_in.handle_slot;
                    n_gen   = i_in.handle_generation;
                    n_dense = i_in.dense_value;
                    n_res   = '{status: ght_pkg::ST_OK, slot: '0, gen: '0, dense: '0};
                    if (in_kind == ght_pkg::KIND_ALLOC) begin
                        if (r_depth != '0) begin
                            // pop the free stack
                            stk_re  = 1'b1;
                            n_depth = depth_dec;
                            n_state = S_STK;
                        end else if (r_used != CNT_W'(ght_pkg::SLOTS)) begin
                            // fresh slot starts at generation zero
                            ent_we    = 1'b1;
                            ent_waddr = r_used[SLOT_W-1:0];
                            ent_wdata = '{gen: '0, dense: i_in.dense_value};
                            n_res.slot = r_used[SLOT_W-1:0];
                            n_used    = r_used + CNT_W'(1);
                            n_state   = S_RES;
                        end else begin
                            n_res.status = ght_pkg::ST_FULL;
                            n_state      = S_RES;
                        end
                    end else if (!in_known || (in_kind == ght_pkg::KIND_RELEASE &&
                                 r_depth == CNT_W'(ght_pkg::SLOTS))) begin
                        n_res.status = ght_pkg::ST_RANGE;
                        n_state      = S_RES;
                    end else begin
                        ent_re  = 1'b1;
                        n_state = S_ENT;
                    end
                end
            end
            S_STK: begin
                ent_re    = 1'b1;
                ent_raddr = stk_rdata;
                n_slot    = stk_rdata;
                n_state   = S_ENT;
            end
            S_ENT: begin
                n_state = S_RES;
                case (r_kind)
                    ght_pkg::KIND_ALLOC: begin
                        ent_we    = 1'b1;
                        ent_wdata = '{gen: ent_rdata.gen, dense: r_dense};
                        n_res.slot = r_slot;
                        n_res.gen  = ent_rdata.gen;
                    end
                    ght_pkg::KIND_RESOLVE: begin
                        if (ent_rdata.gen != r_gen) begin
                            n_res.status = ght_pkg::ST_STALE;
                        end else begin
                            n_res.dense = ent_rdata.dense;
                        end
                    end
                    ght_pkg::KIND_UPDATE: begin
                        ent_we    = 1'b1;
                        ent_wdata = '{gen: ent_rdata.gen, dense: r_dense};
                    end
                    ght_pkg::KIND_RELEASE: begin
                        ent_we    = 1'b1;
                        ent_wdata = '{gen: ent_rdata.gen + 1'b1, dense: ent_rdata.dense};
                        stk_we    = 1'b1;
                        n_depth   = r_depth + CNT_W'(1);
                    end
                    default: begin
                        n_res.status = ght_pkg::ST_RANGE;
                    end
                endcase
            end
            S_RES: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_slot  <= n_slot;
        r_gen   <= n_gen;
        r_dense <= n_dense;
        r_res   <= n_res;
    end

    ght_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ght_pkg::SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rword)
    );

    ght_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ght_pkg::SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    ght_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (r_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_depth_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(ght_pkg::SLOTS))
        else $error("free stack depth beyond capacity");

    a_used_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(ght_pkg::SLOTS))
        else $error("slot count beyond capacity");

    a_one_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input taken while an item is in flight");

    a_pop_only_alloc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STK |-> r_kind == ght_pkg::KIND_ALLOC)
        else $error("stack pop outside of alloc");

    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten");
`endif

endmodule
